FILE: rtl/fca_pkg.sv
// shared types, defaults and register codes of the flagged channel averager
package fca_pkg;

  // default sizes handed to the top level
  localparam int DEF_MAX_POLS     = 4;
  localparam int DEF_MAX_STEP     = 64;
  localparam int DEF_MAX_CHANNELS = 4096;

  // fixed field widths
  localparam int DATA_W     = 24;
  localparam int WEIGHT_W   = 16;
  localparam int START_W    = 12;
  localparam int STEP_REG_W = 7;
  localparam int OUT_CH_W   = 13;
  localparam int NPOL_REG_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int MAX_OUT_CH = 4096;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_CHANNEL = 3'd0,
    CFG_CHANNEL_STEP  = 3'd1,
    CFG_OUT_CHANNELS  = 3'd2,
    CFG_NUM_POLS      = 3'd3,
    CFG_USE_WEIGHTS   = 3'd4
  } fca_cfg_idx_e;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } fca_state_e;

  // accumulator memory control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_all;
  } fca_mem_ctl_t;

endpackage

FILE: rtl/flagged_channel_averager.sv
// Flagged channel averager: takes one complex sample per beat (polarization
// fastest, then channel) and keeps per-polarization sums in a small
// accumulator memory that is read, updated and written back. A sample that
// does not close a group passes through read, multiply and add with write
// back before the next accept; a sample outside the used range is taken
// without leaving idle. A sample that closes a group also runs the two
// shift-subtract dividers, then waits until the output register is free.
// One sample is in work at a time.
module flagged_channel_averager import fca_pkg::*; #(
  parameter int MAX_POLS     = DEF_MAX_POLS,
  parameter int MAX_STEP     = DEF_MAX_STEP,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  localparam int CNTW        = $clog2(MAX_STEP + 1),
  localparam int WSW         = WEIGHT_W + CNTW - 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [DATA_W-1:0] data_re_i,
  input  logic signed [DATA_W-1:0] data_im_i,
  input  logic                  flagged_i,
  input  logic [WEIGHT_W-1:0]   weight_i,
  input  logic                  row_start_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [DATA_W-1:0] avg_re_o,
  output logic signed [DATA_W-1:0] avg_im_o,
  output logic [WSW-1:0]        weight_sum_o,
  output logic                  out_flag_o,
  output logic [1:0]            pol_index_o,
  output logic [11:0]           out_channel_o,
  output logic                  last_of_row_o
);

  localparam int PW     = (MAX_POLS > 1) ? $clog2(MAX_POLS) : 1;
  localparam int NPW    = $clog2(MAX_POLS + 1);
  localparam int SUMW   = 41 + CNTW;
  localparam int CHW    = $clog2(MAX_CHANNELS) + 1;
  localparam int CMPW   = (CHW > START_W) ? CHW : START_W;
  localparam int WORD_W = 2 * SUMW + WSW + CNTW;
  localparam int PRODW  = DATA_W + WEIGHT_W + 1;

  // configuration registers
  logic [START_W-1:0]    cfg_start_q;
  logic [STEP_REG_W-1:0] cfg_step_q;
  logic [OUT_CH_W-1:0]   cfg_nout_q;
  logic [NPOL_REG_W-1:0] cfg_npol_q;
  logic                  cfg_usew_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_start_q <= '0;
      cfg_step_q  <= STEP_REG_W'(1);
      cfg_nout_q  <= OUT_CH_W'(1);
      cfg_npol_q  <= NPOL_REG_W'(1);
      cfg_usew_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_CHANNEL: cfg_start_q <= cfg_data_i[START_W-1:0];
        CFG_CHANNEL_STEP:  cfg_step_q  <= cfg_data_i[STEP_REG_W-1:0];
        CFG_OUT_CHANNELS:  cfg_nout_q  <= cfg_data_i[OUT_CH_W-1:0];
        CFG_NUM_POLS:      cfg_npol_q  <= cfg_data_i[NPOL_REG_W-1:0];
        CFG_USE_WEIGHTS:   cfg_usew_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamped register values
  logic [CNTW-1:0]     step_c;
  logic [NPW-1:0]      npol_c;
  logic [OUT_CH_W-1:0] nout_c;

  always_comb begin
    if (cfg_step_q == '0) begin
      step_c = CNTW'(1);
    end else if (int'(cfg_step_q) > MAX_STEP) begin
      step_c = CNTW'(MAX_STEP);
    end else begin
      step_c = CNTW'(cfg_step_q);
    end
    if (cfg_npol_q == '0) begin
      npol_c = NPW'(1);
    end else if (int'(cfg_npol_q) > MAX_POLS) begin
      npol_c = NPW'(MAX_POLS);
    end else begin
      npol_c = NPW'(cfg_npol_q);
    end
    if (cfg_nout_q == '0) begin
      nout_c = OUT_CH_W'(1);
    end else if (int'(cfg_nout_q) > MAX_OUT_CH) begin
      nout_c = OUT_CH_W'(MAX_OUT_CH);
    end else begin
      nout_c = cfg_nout_q;
    end
  end

  // stream position
  logic [CHW-1:0]      ich_q, ich_d;
  logic [PW-1:0]       pol_q, pol_d;
  logic [CNTW-1:0]     grp_q, grp_d;
  logic [OUT_CH_W-1:0] och_q, och_d;

  fca_state_e state_q, state_d;
  logic accept;

  logic [CHW-1:0]      ich_e;
  logic [PW-1:0]       pol_e;
  logic [CNTW-1:0]     grp_e;
  logic [OUT_CH_W-1:0] och_e;
  logic [NPW-1:0]      p_ext;
  logic [NPW-1:0]      p_inc;
  logic [CNTW-1:0]     grp_inc;
  logic                in_range;
  logic                group_end;
  logic                row_last;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // position bookkeeping for the sample at the input
  always_comb begin
    ich_e = row_start_i ? '0 : ich_q;
    grp_e = row_start_i ? '0 : grp_q;
    och_e = row_start_i ? '0 : och_q;
    pol_e = row_start_i ? '0 : pol_q;
    if (NPW'(pol_e) >= npol_c) begin
      pol_e = '0;
    end
    p_ext   = NPW'(pol_e);
    p_inc   = p_ext + 1'b1;
    grp_inc = grp_e + 1'b1;
    in_range = (CMPW'(ich_e) >= CMPW'(cfg_start_q)) &&
               (ich_e < CHW'(MAX_CHANNELS)) && (och_e < nout_c);
    group_end = in_range && (grp_inc >= step_c);
    row_last  = (OUT_CH_W'(och_e + 1'b1) == nout_c) && (p_inc == npol_c);

    ich_d = ich_e;
    grp_d = grp_e;
    och_d = och_e;
    if (p_inc >= npol_c) begin
      pol_d = '0;
      if (in_range) begin
        if (grp_inc >= step_c) begin
          grp_d = '0;
          och_d = och_e + 1'b1;
        end else begin
          grp_d = grp_inc;
        end
      end
      if (ich_e < CHW'(MAX_CHANNELS)) begin
        ich_d = ich_e + 1'b1;
      end
    end else begin
      pol_d = p_inc[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ich_q <= '0;
      pol_q <= '0;
      grp_q <= '0;
      och_q <= '0;
    end else if (accept) begin
      ich_q <= ich_d;
      pol_q <= pol_d;
      grp_q <= grp_d;
      och_q <= och_d;
    end
  end

  // captured beat
  logic signed [DATA_W-1:0] in_re_q, in_im_q;
  logic                     in_flag_q;
  logic [WEIGHT_W-1:0]      in_w_q;
  logic [PW-1:0]            p_q;
  logic                     group_end_q;
  logic                     row_last_q;
  logic [11:0]              och_out_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_re_q     <= data_re_i;
      in_im_q     <= data_im_i;
      in_flag_q   <= flagged_i;
      in_w_q      <= weight_i;
      p_q         <= pol_e;
      group_end_q <= group_end;
      row_last_q  <= row_last;
      och_out_q   <= och_e[11:0];
    end
  end

  // accumulator memory
  fca_mem_ctl_t      mem_ctl;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] wr_word;

  assign mem_ctl.rd_en     = accept;
  assign mem_ctl.clear_all = accept && row_start_i;
  assign mem_ctl.wr_en     = (state_q == ST_ADD);

  fca_acc_mem #(
    .DEPTH  (MAX_POLS),
    .ADDR_W (PW),
    .WORD_W (WORD_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (pol_e),
    .wr_addr_i (p_q),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word)
  );

  // sample contribution, weighted or plain
  logic signed [PRODW-1:0] mul_re, mul_im;
  logic signed [SUMW-1:0]  prod_re_q, prod_im_q;

  assign mul_re = in_re_q * $signed({1'b0, in_w_q});
  assign mul_im = in_im_q * $signed({1'b0, in_w_q});

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      if (cfg_usew_q) begin
        prod_re_q <= {{(SUMW-PRODW){mul_re[PRODW-1]}}, mul_re};
        prod_im_q <= {{(SUMW-PRODW){mul_im[PRODW-1]}}, mul_im};
      end else begin
        prod_re_q <= {{(SUMW-DATA_W){in_re_q[DATA_W-1]}}, in_re_q};
        prod_im_q <= {{(SUMW-DATA_W){in_im_q[DATA_W-1]}}, in_im_q};
      end
    end
  end

  // read-modify-write of the entry
  logic signed [SUMW-1:0] rd_re, rd_im, new_re, new_im;
  logic [WSW-1:0]         rd_ws, new_ws;
  logic [CNTW-1:0]        rd_cnt, new_cnt;
  logic                   good;

  assign {rd_re, rd_im, rd_ws, rd_cnt} = rd_word;
  assign good    = !in_flag_q;
  assign new_re  = good ? rd_re + prod_re_q : rd_re;
  assign new_im  = good ? rd_im + prod_im_q : rd_im;
  assign new_ws  = (good && cfg_usew_q) ? rd_ws + WSW'(in_w_q) : rd_ws;
  assign new_cnt = good ? rd_cnt + 1'b1 : rd_cnt;
  assign wr_word = group_end_q ? '0 : {new_re, new_im, new_ws, new_cnt};

  // group result held across the division
  logic           neg_re_q, neg_im_q, empty_q;
  logic [WSW-1:0] ws_q;
  logic           div_start;
  logic [SUMW-1:0] mag_re, mag_im;
  logic [WSW-1:0]  den;

  assign div_start = (state_q == ST_ADD) && group_end_q;
  assign mag_re    = new_re[SUMW-1] ? SUMW'(-new_re) : SUMW'(new_re);
  assign mag_im    = new_im[SUMW-1] ? SUMW'(-new_im) : SUMW'(new_im);
  assign den       = cfg_usew_q ? new_ws : WSW'(new_cnt);

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      neg_re_q <= new_re[SUMW-1];
      neg_im_q <= new_im[SUMW-1];
      empty_q  <= (new_cnt == '0) || (cfg_usew_q && (new_ws == '0));
      ws_q     <= cfg_usew_q ? new_ws : '0;
    end
  end

  // dividers for both parts
  logic            busy_re, busy_im;
  logic [SUMW-1:0] quo_re, quo_im;

  fca_div #(.NUM_W(SUMW), .DEN_W(WSW)) u_div_re (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag_re),
    .den_i   (den),
    .busy_o  (busy_re),
    .quot_o  (quo_re)
  );

  fca_div #(.NUM_W(SUMW), .DEN_W(WSW)) u_div_im (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag_im),
    .den_i   (den),
    .busy_o  (busy_im),
    .quot_o  (quo_im)
  );

  // sign restore and saturation to q1.23
  localparam logic [SUMW-1:0] POS_LIM = SUMW'(8388607);
  localparam logic [SUMW-1:0] NEG_LIM = SUMW'(8388608);
  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0] res_re, res_im;

  always_comb begin
    if (empty_q) begin
      res_re = '0;
    end else if (!neg_re_q) begin
      res_re = (quo_re > POS_LIM) ? POS_MAX : quo_re[DATA_W-1:0];
    end else begin
      res_re = (quo_re > NEG_LIM) ? NEG_MAX : DATA_W'(-quo_re[DATA_W-1:0]);
    end
    if (empty_q) begin
      res_im = '0;
    end else if (!neg_im_q) begin
      res_im = (quo_im > POS_LIM) ? POS_MAX : quo_im[DATA_W-1:0];
    end else begin
      res_im = (quo_im > NEG_LIM) ? NEG_MAX : DATA_W'(-quo_im[DATA_W-1:0]);
    end
  end

  // sequencer
  logic out_load;
  logic out_valid_q;

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && in_range) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = group_end_q ? ST_DIV : ST_IDLE;
      ST_DIV:  if (!busy_re && !busy_im) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_re_o      <= res_re;
      avg_im_o      <= res_im;
      weight_sum_o  <= empty_q ? '0 : ws_q;
      out_flag_o    <= empty_q;
      pol_index_o   <= 2'(p_q);
      out_channel_o <= och_out_q;
      last_of_row_o <= row_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/fca_acc_mem.sv
// per-polarization accumulator memory with entry valid bits
module fca_acc_mem import fca_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_POLS,
  parameter int ADDR_W = 2,
  parameter int WORD_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fca_mem_ctl_t      ctl_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [WORD_W-1:0] rd_data_q;
  logic              rd_valid_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // valid bits, an entry never written since a clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clear_all) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i] && !ctl_i.clear_all;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: rtl/fca_div.sv
// restoring divider, one quotient bit per cycle
module fca_div import fca_pkg::*; #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  // one shift and trial subtract
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    if (shifted >= {1'b0, den_q}) begin
      rem_d = diff[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], 1'b1};
    end else begin
      rem_d = shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], 1'b0};
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CNT_W'(NUM_W - 1);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = run_q;
  assign quot_o = quo_q;

endmodule
